// File: src/assert_macros.svh
// Assertion macros for the character LCD bus sequencer, used by lcdseq_ctrl.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// File: src/lcdseq_pkg.sv
// Shared types, timing constants and start-up command table for the
// character LCD bus sequencer. No dependencies.
package lcdseq_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_CMD  = 2'd0,
      REQ_CHAR = 2'd1,
      REQ_INIT = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   // Hold times in ms
   localparam logic [9:0] HOLD_WAIT_MS    = 10'd1000;
   localparam logic [9:0] HOLD_EN_HIGH_MS = 10'd1;
   localparam logic [9:0] HOLD_LOW_8B_MS  = 10'd5;
   localparam logic [9:0] HOLD_LOW_4B_MS  = 10'd3;

   // Index of the final start-up command per bus mode
   localparam logic [2:0] INIT_LAST_4B = 3'd5;
   localparam logic [2:0] INIT_LAST_8B = 3'd3;

   // Controller to datapath command
   typedef struct packed {
      logic       load;        // capture request byte and RS
      logic       emit;        // write next pin state to output register
      logic       wait_state;  // pin state is the power-up wait
      logic       from_table;  // byte comes from start-up table
      logic [2:0] idx;         // start-up command index
      logic [1:0] phase;       // bit0: EN low half, bit1: low nibble
      logic       last;        // final pin state of the request
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;  // output register can take a pin state this cycle
      logic four_bit;  // bus mode register
   } dp_status_type;

   // Start-up command bytes
   function automatic logic [7:0] init_cmd(input logic four_bit, input logic [2:0] idx);
      logic [7:0] code;
      code = 8'h00;
      if (four_bit) begin
         unique case (idx)
            3'd0:    code = 8'h33;
            3'd1:    code = 8'h32;
            3'd2:    code = 8'h28;
            3'd3:    code = 8'h0C;
            3'd4:    code = 8'h01;
            3'd5:    code = 8'h02;
            default: code = 8'h00;
         endcase
      end else begin
         unique case (idx)
            3'd0:    code = 8'h38;
            3'd1:    code = 8'h0C;
            3'd2:    code = 8'h01;
            3'd3:    code = 8'h02;
            default: code = 8'h00;
         endcase
      end
      return code;
   endfunction

endpackage

// File: src/lcdseq_ctrl.sv
// Sequencing state machine for the character LCD bus sequencer.
// Depends on lcdseq_pkg and assert_macros.svh; drives lcdseq_dp by command struct.
`include "assert_macros.svh"
module lcdseq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               req_kind,
   input  lcdseq_pkg::dp_status_type status,
   output lcdseq_pkg::dp_cmd_type    cmd
);
   import lcdseq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_SEND
   } state_type;

   state_type  state_ff;
   logic       init_ff;
   logic [2:0] idx_ff;
   logic [1:0] phase_ff;

   logic fire;
   logic last_phase;
   logic idx_last;

   // Handshake and end-of-byte / end-of-run detection
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      fire       = req_tvalid & req_tready;
      last_phase = phase_ff[0] & (phase_ff[1] | ~status.four_bit);
      idx_last   = status.four_bit ? (idx_ff >= INIT_LAST_4B) : (idx_ff >= INIT_LAST_8B);
   end

   // Command to datapath
   always_comb begin
      cmd.load       = fire;
      cmd.emit       = status.out_free & (state_ff != ST_IDLE);
      cmd.wait_state = (state_ff == ST_WAIT);
      cmd.from_table = init_ff;
      cmd.idx        = idx_ff;
      cmd.phase      = phase_ff;
      cmd.last       = (state_ff == ST_SEND) & last_phase & (~init_ff | idx_last);
   end

   // State, phase and command index
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         init_ff  <= 1'b0;
         idx_ff   <= 3'd0;
         phase_ff <= 2'd0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (fire) begin
                  idx_ff   <= 3'd0;
                  phase_ff <= 2'd0;
                  unique case (req_kind_type'(req_kind))
                     REQ_CMD, REQ_CHAR: begin
                        init_ff  <= 1'b0;
                        state_ff <= ST_SEND;
                     end
                     REQ_INIT: begin
                        init_ff  <= 1'b1;
                        state_ff <= ST_WAIT;
                     end
                     REQ_NONE: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_WAIT: begin
               if (cmd.emit) state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (cmd.emit) begin
                  if (cmd.last) begin
                     state_ff <= ST_IDLE;
                  end else if (last_phase) begin
                     phase_ff <= 2'd0;
                     idx_ff   <= idx_ff + 3'd1;
                  end else begin
                     phase_ff <= phase_ff + 2'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_AT(a_last_to_idle, clock, reset, cmd.emit && cmd.last |=> state_ff == ST_IDLE, "run did not end after its last pin state")
   `ASSERT_NEVER(a_idx_range, clock, reset, idx_ff > INIT_LAST_4B, "start-up index beyond table")
   `ASSERT_AT(a_wait_then_send, clock, reset, cmd.emit && cmd.wait_state |=> state_ff == ST_SEND && idx_ff == 3'd0 && phase_ff == 2'd0, "start-up wait not followed by first command")

endmodule

// File: src/lcdseq_dp.sv
// Datapath for the character LCD bus sequencer: mode register, request
// capture, pin state formation and output register. Depends on lcdseq_pkg.
module lcdseq_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_wdata,
   input  logic [7:0]                req_byte,
   input  logic [1:0]                req_kind,
   input  lcdseq_pkg::dp_cmd_type    cmd,
   output lcdseq_pkg::dp_status_type status,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [23:0]               rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);
   import lcdseq_pkg::*;

   logic       four_bit_ff;
   logic [7:0] byte_ff;
   logic       rs_ff;
   logic       rsp_valid_ff;
   logic       out_rs_ff;
   logic       out_en_ff;
   logic [7:0] out_data_ff;
   logic [9:0] out_hold_ff;
   logic       out_last_ff;

   logic [7:0] byte_sel;
   logic [3:0] nibble;
   logic       rs_in;
   logic       en_in;
   logic [7:0] data_in;
   logic [9:0] hold_in;

   // Bus mode register
   always_ff @(posedge clock) begin
      if (reset) four_bit_ff <= 1'b1;
      else if (csr_we) four_bit_ff <= csr_wdata;
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_byte;
         rs_ff   <= (req_kind_type'(req_kind) == REQ_CHAR);
      end
   end

   // Next pin state
   always_comb begin
      byte_sel = cmd.from_table ? init_cmd(four_bit_ff, cmd.idx) : byte_ff;
      nibble   = cmd.phase[1] ? byte_sel[3:0] : byte_sel[7:4];
      if (cmd.wait_state) begin
         rs_in   = 1'b0;
         en_in   = 1'b0;
         data_in = 8'h00;
         hold_in = HOLD_WAIT_MS;
      end else begin
         rs_in   = rs_ff & ~cmd.from_table;
         en_in   = ~cmd.phase[0];
         data_in = four_bit_ff ? {4'h0, nibble} : byte_sel;
         if (!cmd.phase[0]) hold_in = HOLD_EN_HIGH_MS;
         else hold_in = four_bit_ff ? HOLD_LOW_4B_MS : HOLD_LOW_8B_MS;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_rs_ff   <= rs_in;
         out_en_ff   <= en_in;
         out_data_ff <= data_in;
         out_hold_ff <= hold_in;
         out_last_ff <= cmd.last;
      end
   end

   always_comb begin
      status.out_free = ~rsp_valid_ff | rsp_tready;
      status.four_bit = four_bit_ff;
      rsp_tvalid      = rsp_valid_ff;
      rsp_tdata       = {5'b0, out_hold_ff, out_data_ff, out_en_ff};
      rsp_tuser       = out_rs_ff;
      rsp_tlast       = out_last_ff;
   end

endmodule

// File: src/char_lcd_bus_sequencer.sv
// Character LCD bus sequencer: one request in, a run of timed pin states out (none
// for REQ_NONE). Start: the transfer moves the controller out of idle; the first pin
// state is registered once the output register is free. Throughput: one pin state
// per cycle while the receiver accepts; a command or character is 4 states (4-bit)
// or 2 (8-bit), start-up 25 or 9; the next request waits until the last is registered.
// Reset: synchronous; bus mode returns to 4-bit and the output register empties.
module char_lcd_bus_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,     // four_bit_bus
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] data_byte
   input  logic [1:0]  req_tuser,     // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // [0] enable_line, [8:1] data_lines, [18:9] hold_ms
   output logic        rsp_tuser,     // [0] reg_select
   output logic        rsp_tlast      // last
);
   import lcdseq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing control
   lcdseq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // Pin state datapath
   lcdseq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_byte   (req_tdata),
      .req_kind   (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/sv/char_lcd_bus_sequencer_tb.sv
// Self-checking testbench for the character LCD bus sequencer: drives command,
// character, start-up and unused requests under both bus modes and checks every pin state.
// Depends on lcdseq_pkg and char_lcd_bus_sequencer.
module char_lcd_bus_sequencer_tb;
   import lcdseq_pkg::*;

   // Expected bus timing in ms
   localparam logic [9:0] T_STARTUP = 10'd1000;
   localparam logic [9:0] T_EN_HIGH = 10'd1;
   localparam logic [9:0] T_LOW_8B  = 10'd5;
   localparam logic [9:0] T_LOW_4B  = 10'd3;

   // Start-up command bytes, first command in the top byte
   localparam logic [47:0] STARTUP_SEQ_4B = 48'h33_32_28_0C_01_02;
   localparam logic [31:0] STARTUP_SEQ_8B = 32'h38_0C_01_02;

   localparam int MAX_REPORTS = 10;

   typedef struct {
      req_kind_type kind;
      logic [7:0]   code;
   } lcd_req_type;

   typedef struct {
      logic       reg_sel;
      logic       en;
      logic [7:0] bus;
      logic [9:0] hold_ms;
      logic       last;
   } pin_state_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // [7:0] data_byte
   logic [1:0]  req_tuser  = REQ_CMD; // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [0] enable_line, [8:1] data_lines, [18:9] hold_ms
   logic        rsp_tuser;           // [0] reg_select
   logic        rsp_tlast;

   lcd_req_type   pending_reqs[$];
   pin_state_type expected_pins[$];

   logic bus_four_bit = 1'b1;  // mirror of the bus mode register
   bit   idling_on    = 1'b1;
   int   idle_odds    = 4;
   int   send_idle    = 0;
   int   rx_idle      = 0;
   int   rx_long_hold = 0;
   int   error_count  = 0;

   char_lcd_bus_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Run limit
   initial begin
      #20000000;
      $display("Test completed with failures");
      $finish;
   end

   // Expected pin states
   function automatic void push_pin(input logic rs, input logic en, input logic [7:0] bus,
                                    input logic [9:0] hold_ms);
      pin_state_type p;
      p.reg_sel = rs;
      p.en      = en;
      p.bus     = bus;
      p.hold_ms = hold_ms;
      p.last    = 1'b0;
      expected_pins.push_back(p);
   endfunction

   function automatic void push_lcd_write(input logic rs, input logic [7:0] code);
      if (bus_four_bit) begin
         push_pin(rs, 1'b1, {4'h0, code[7:4]}, T_EN_HIGH);
         push_pin(rs, 1'b0, {4'h0, code[7:4]}, T_LOW_4B);
         push_pin(rs, 1'b1, {4'h0, code[3:0]}, T_EN_HIGH);
         push_pin(rs, 1'b0, {4'h0, code[3:0]}, T_LOW_4B);
      end else begin
         push_pin(rs, 1'b1, code, T_EN_HIGH);
         push_pin(rs, 1'b0, code, T_LOW_8B);
      end
   endfunction

   function automatic void predict_pins(input req_kind_type kind, input logic [7:0] code);
      int i;
      case (kind)
         REQ_CMD:  push_lcd_write(1'b0, code);
         REQ_CHAR: push_lcd_write(1'b1, code);
         REQ_INIT: begin
            push_pin(1'b0, 1'b0, 8'h00, T_STARTUP);
            if (bus_four_bit) begin
               for (i = 0; i < 6; i++)
                  push_lcd_write(1'b0, STARTUP_SEQ_4B[47 - 8 * i -: 8]);
            end else begin
               for (i = 0; i < 4; i++)
                  push_lcd_write(1'b0, STARTUP_SEQ_8B[31 - 8 * i -: 8]);
            end
         end
         default: return;  // unused request kind: no pin states
      endcase
      expected_pins[expected_pins.size() - 1].last = 1'b1;
   endfunction

   // Request driver: holds each item until its transfer, then maybe idles
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            void'(pending_reqs.pop_front());
         if (send_idle > 0) begin
            send_idle--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (idling_on && $urandom_range(0, idle_odds) == 0) begin
            send_idle = $urandom_range(0, 11);
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_reqs[0].code;
            req_tuser  <= pending_reqs[0].kind;
         end
      end
   end

   // Result receiver: long hold-off on request, else random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_long_hold > 0) begin
         rx_long_hold--;
         rsp_tready <= 1'b0;
      end else if (rx_idle > 0) begin
         rx_idle--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, idle_odds) == 0) begin
         rx_idle = $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: tracks the mode register, predicts on request transfers, checks results
   always @(posedge clock) begin
      pin_state_type exp_pin;
      if (reset) begin
         bus_four_bit = 1'b1;
      end else begin
         if (csr_we)
            bus_four_bit = csr_wdata;
         if (req_tvalid && req_tready)
            predict_pins(req_kind_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pins.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected pin state: tdata=%06h tuser=%0d tlast=%0d",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               exp_pin = expected_pins.pop_front();
               if (rsp_tuser !== exp_pin.reg_sel || rsp_tdata[0] !== exp_pin.en ||
                   rsp_tdata[8:1] !== exp_pin.bus || rsp_tdata[18:9] !== exp_pin.hold_ms ||
                   rsp_tdata[23:19] !== 5'd0 || rsp_tlast !== exp_pin.last) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("pin state mismatch: expected rs=%0d en=%0d data=%02h hold=%0d last=%0d",
                              exp_pin.reg_sel, exp_pin.en, exp_pin.bus, exp_pin.hold_ms,
                              exp_pin.last);
                     $display("   got rs=%0d en=%0d data=%02h hold=%0d last=%0d pad=%02h",
                              rsp_tuser, rsp_tdata[0], rsp_tdata[8:1], rsp_tdata[18:9],
                              rsp_tlast, rsp_tdata[23:19]);
                  end
               end
            end
         end
      end
   end

   task automatic queue_req(input req_kind_type kind, input logic [7:0] code);
      lcd_req_type r;
      r.kind = kind;
      r.code = code;
      pending_reqs.push_back(r);
   endtask

   // Wait until every request has gone and every pin state has come back,
   // then give an ignored request time to clear the block
   task automatic drain();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || expected_pins.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // Mode register write, block idle
   task automatic set_bus_mode(input logic four_bit);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= four_bit;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // Stimulus
   initial begin
      int phase;
      int pick;
      req_kind_type kind;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset mode is the 4-bit bus
      queue_req(REQ_INIT, 8'h00);
      queue_req(REQ_CMD, 8'h00);
      queue_req(REQ_CMD, 8'hFF);
      queue_req(REQ_CHAR, 8'h00);
      queue_req(REQ_CHAR, 8'hFF);
      queue_req(REQ_CHAR, 8'hA5);
      queue_req(REQ_NONE, 8'h3C);
      queue_req(REQ_CMD, 8'h5A);
      drain();
      set_bus_mode(1'b0);
      queue_req(REQ_INIT, 8'hFF);
      queue_req(REQ_CMD, 8'hFF);
      queue_req(REQ_CHAR, 8'h00);
      queue_req(REQ_CHAR, 8'h80);
      queue_req(REQ_NONE, 8'hFF);
      queue_req(REQ_CMD, 8'h7F);
      queue_req(REQ_INIT, 8'h5A);
      drain();
      set_bus_mode(1'b1);
      queue_req(REQ_CHAR, 8'h5A);
      queue_req(REQ_INIT, 8'hA5);
      queue_req(REQ_NONE, 8'h00);
      queue_req(REQ_CMD, 8'h01);
      drain();

      // Random phases; phase 2 starts with a long receiver hold-off,
      // the last phase runs without idling
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 0)
            set_bus_mode(1'b0);
         else if (phase == 1)
            set_bus_mode(1'b1);
         else
            set_bus_mode(1'($urandom_range(0, 1)));
         idle_odds = $urandom_range(2, 20);
         if (phase == 2)
            rx_long_hold = 400;
         if (phase == 5)
            idling_on = 1'b0;
         repeat (38) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               kind = REQ_INIT;
            else if (pick == 1)
               kind = REQ_NONE;
            else if (pick < 11)
               kind = REQ_CMD;
            else
               kind = REQ_CHAR;
            queue_req(kind, 8'($urandom_range(0, 255)));
         end
         drain();
      end

      repeat (20) @(negedge clock);
      if (error_count == 0 && expected_pins.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/lcdseq_pkg.sv
src/lcdseq_ctrl.sv
src/lcdseq_dp.sv
src/char_lcd_bus_sequencer.sv
tb/sv/char_lcd_bus_sequencer_tb.sv
